// ===== sv/alte_pkg.sv =====
// ----------------------------------------------------------------------------
// alte_pkg: shared types for the array list table engine
// Holds the request codes, the result codes, the per-cell shift command and
// the probe word that travels down the row of cells.
// ----------------------------------------------------------------------------
package alte_pkg;

	localparam int SLOT_W = 6;
	localparam int POS_W  = 7;
	localparam int OUT_W  = 32;

	typedef enum logic [2:0] {
		K_CLEAR  = 3'd0,
		K_INSERT = 3'd1,
		K_DELETE = 3'd2,
		K_LOCATE = 3'd3,
		K_READ   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_POS   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Broadcast to every cell in the cycle an insert or delete is taken
	typedef struct packed {
		logic              ins;
		logic              del;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	// Probe body; its valid bit travels beside it
	typedef struct packed {
		logic              is_read;
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic [POS_W-1:0]  pos;
	} probe_t;

endpackage

// ===== sv/alte_cell.sv =====
// ----------------------------------------------------------------------------
// alte_cell: one position of the list
// Holds one entry, shifts it with its neighbors on insert and delete, and
// passes the search/read probe on to the next cell each cycle.
// ----------------------------------------------------------------------------
module alte_cell #(
	parameter int IDX = 0,
	parameter int DW  = 32,
	parameter int CW  = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  alte_pkg::cmd_t       cmd,
	input  logic [DW-1:0]        ins_word,
	input  logic [DW-1:0]        left,
	input  logic [DW-1:0]        right,
	input  logic [CW-1:0]        count,
	input  logic                 pv_in,
	input  alte_pkg::probe_t     pb_in,
	input  logic [DW-1:0]        pw_in,
	output logic                 pv_out,
	output alte_pkg::probe_t     pb_out,
	output logic [DW-1:0]        pw_out,
	output logic [DW-1:0]        entry
);
	import alte_pkg::*;

	logic [DW-1:0] entry_q;
	logic          pv_q;
	probe_t        pb_q;
	logic [DW-1:0] pw_q;
	probe_t        pb_d;
	logic [DW-1:0] pw_d;
	logic [31:0]   slot_x;
	logic          live;

	assign slot_x = 32'(cmd.slot);
	assign live   = IDX < 32'(count);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (slot_x == IDX) begin
				entry_q <= ins_word;
			end else if (IDX > slot_x) begin
				entry_q <= left;
			end
		end else if (cmd.del && IDX >= slot_x) begin
			entry_q <= right;
		end
	end

	// Mark the first hit; later cells leave a marked probe alone
	always_comb begin
		pb_d = pb_in;
		pw_d = pw_in;
		if (pv_in && !pb_in.hit) begin
			if (pb_in.is_read) begin
				if (32'(pb_in.slot) == IDX) begin
					pb_d.hit = 1'b1;
					pw_d     = entry_q;
				end
			end else if (live && entry_q == pw_in) begin
				pb_d.hit = 1'b1;
				pb_d.pos = POS_W'(IDX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
		end else begin
			pv_q <= pv_in;
		end
	end

	always_ff @(posedge clk) begin
		pb_q <= pb_d;
		pw_q <= pw_d;
	end

	assign pv_out = pv_q;
	assign pb_out = pb_q;
	assign pw_out = pw_q;
	assign entry  = entry_q;

endmodule

// ===== sv/array_list_table_engine.sv =====
// ----------------------------------------------------------------------------
// array_list_table_engine: ordered list of up to DEPTH words with a count
// Clear, insert at a position, delete at a position, locate a value, read a
// position. One result word per request word.
// ----------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   request   in         in_valid / in_stall   kind, slot, value
//   result    out        out_valid / out_stall status, read_value, found_slot
//
// Clear, insert and delete update the list at the edge they are taken; the
// whole row of cells shifts at once on insert and delete. Their result word,
// like that of a rejected request, is parked at acceptance and then moves to
// the output register. Locate and an in-range read send a probe down the cell
// row; its result word is parked as the probe leaves the last cell.
// The next request is taken once the parked result moves to the output
// register; out_stall holds the output register and, behind it, the parked
// result. Reset clears the count.
// ----------------------------------------------------------------------------
module array_list_table_engine #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [5:0]  slot,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] read_value,
	output logic [6:0]  found_slot
);
	import alte_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = DATA_WIDTH;

	logic [CW-1:0]  count_q;
	logic           flight_q;
	logic           pend_valid_q;
	status_t        pend_status_q;
	logic [31:0]    pend_rd_q;
	logic [6:0]     pend_pos_q;
	logic           out_valid_q;
	status_t        out_status_q;
	logic [31:0]    out_rd_q;
	logic [6:0]     out_pos_q;

	logic           accept;
	logic           move;
	logic           launch;
	logic           do_ins;
	logic           do_del;
	logic           do_clr;
	status_t        imm_status;
	logic [6:0]     imm_pos;
	logic [31:0]    slot_x;
	logic [31:0]    cnt_x;
	logic [DW-1:0]  word;
	cmd_t           cmd;
	kind_t          k;

	logic [DEPTH:0] pv;
	probe_t         pb [DEPTH+1];
	logic [DW-1:0]  pw [DEPTH+1];
	logic [DW-1:0]  ent [DEPTH];
	status_t        exit_status;
	logic [6:0]     exit_pos;

	assign in_stall = pend_valid_q || flight_q;
	assign accept   = in_valid && !in_stall;
	assign move     = pend_valid_q && (!out_valid_q || !out_stall);
	assign slot_x   = 32'(slot);
	assign cnt_x    = 32'(count_q);
	assign word     = DW'(value);
	assign k        = kind_t'(kind);

	always_comb begin
		launch     = 1'b0;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		do_clr     = 1'b0;
		imm_status = ST_BAD_POS;
		imm_pos    = 7'(count_q);
		case (k)
			K_CLEAR: begin
				do_clr     = 1'b1;
				imm_status = ST_OK;
				imm_pos    = '0;
			end
			K_INSERT: begin
				if (cnt_x >= DEPTH) begin
					imm_status = ST_FULL;
				end else if (slot_x > cnt_x) begin
					imm_status = ST_BAD_POS;
				end else begin
					do_ins     = 1'b1;
					imm_status = ST_OK;
					imm_pos    = 7'(count_q + CW'(1));
				end
			end
			K_DELETE: begin
				if (slot_x < cnt_x) begin
					do_del     = 1'b1;
					imm_status = ST_OK;
					imm_pos    = 7'(count_q - CW'(1));
				end
			end
			K_LOCATE: begin
				launch = 1'b1;
			end
			K_READ: begin
				if (slot_x < cnt_x) begin
					launch = 1'b1;
				end
			end
			default: begin
				imm_status = ST_BAD_POS;
			end
		endcase
	end

	assign cmd.ins  = accept && do_ins;
	assign cmd.del  = accept && do_del;
	assign cmd.slot = slot;

	assign pv[0]         = accept && launch;
	assign pb[0].is_read = (k == K_READ);
	assign pb[0].slot    = slot;
	assign pb[0].hit     = 1'b0;
	assign pb[0].pos     = '0;
	assign pw[0]         = word;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		alte_cell #(
			.IDX (i),
			.DW  (DW),
			.CW  (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.ins_word (word),
			.left     (ent[(i == 0) ? 0 : i - 1]),
			.right    (ent[(i == DEPTH - 1) ? i : i + 1]),
			.count    (count_q),
			.pv_in    (pv[i]),
			.pb_in    (pb[i]),
			.pw_in    (pw[i]),
			.pv_out   (pv[i+1]),
			.pb_out   (pb[i+1]),
			.pw_out   (pw[i+1]),
			.entry    (ent[i])
		);
	end

	always_comb begin
		if (pb[DEPTH].is_read || pb[DEPTH].hit) begin
			exit_status = ST_OK;
		end else begin
			exit_status = ST_NOT_FOUND;
		end
		if (!pb[DEPTH].is_read && pb[DEPTH].hit) begin
			exit_pos = pb[DEPTH].pos;
		end else begin
			exit_pos = 7'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			flight_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (move) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (launch) begin
					flight_q <= 1'b1;
				end else begin
					pend_valid_q <= 1'b1;
				end
				if (do_clr) begin
					count_q <= '0;
				end else if (do_ins) begin
					count_q <= count_q + CW'(1);
				end else if (do_del) begin
					count_q <= count_q - CW'(1);
				end
			end
			// probe leaves the last cell: park its result
			if (pv[DEPTH]) begin
				flight_q     <= 1'b0;
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !launch) begin
			pend_status_q <= imm_status;
			pend_rd_q     <= '0;
			pend_pos_q    <= imm_pos;
		end else if (pv[DEPTH]) begin
			pend_status_q <= exit_status;
			pend_rd_q     <= pb[DEPTH].is_read ? 32'(pw[DEPTH]) : '0;
			pend_pos_q    <= exit_pos;
		end
		if (move) begin
			out_status_q <= pend_status_q;
			out_rd_q     <= pend_rd_q;
			out_pos_q    <= pend_pos_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign read_value = out_rd_q;
	assign found_slot = out_pos_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= DEPTH)
		else $error("entry count above depth");

	a_one_probe: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pv))
		else $error("more than one probe in the cell row");

	a_probe_exit: assert property (@(posedge clk) disable iff (!arst_n)
		pv[0] |-> ##DEPTH pv[DEPTH])
		else $error("probe did not leave the row after DEPTH cycles");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_valid_q && flight_q))
		else $error("parked result while a probe is in flight");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not advance the count");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the array list table engine
// Request words come from a queue filled up front: a short directed walk over
// the corner cases, then random episodes that fill the list to the top or mix
// all request kinds. A clocked driver and a clocked monitor idle and stall at
// random in three phases. An in-bench list model predicts every result word,
// and the monitor checks each result word against it field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import alte_pkg::*;

	localparam int DEPTH     = 64;
	localparam int N_RANDOM  = 350;
	localparam int TAIL_CYC  = 2 * DEPTH + 16;

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  slot;
		logic [31:0] value;
	} list_request_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] read_value;
		logic [6:0]  found_slot;
	} list_result_t;

	typedef struct packed {
		logic [6:0]             count;
		logic [DEPTH-1:0][31:0] entries;
	} list_state_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [2:0]  kind       = '0;
	logic [5:0]  slot       = '0;
	logic [31:0] value      = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [1:0]  status;
	logic [31:0] read_value;
	logic [6:0]  found_slot;

	list_request_t pending_words[$];
	list_result_t  result_queue[$];
	list_state_t   gen_list;
	list_state_t   model_list;
	list_request_t next_word;
	list_result_t  predicted;
	list_result_t  oldest;
	int            sent_words  = 0;
	int            total_words = 1;
	int            error_count = 0;

	array_list_table_engine #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (32)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.slot       (slot),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.found_slot (found_slot)
	);

	always #5 clk = ~clk;

	// Apply one request to a list copy and return the result word it gives
	function automatic list_result_t list_apply(inout list_state_t st, input logic [2:0] k,
			input logic [5:0] s, input logic [31:0] v);
		list_result_t r;
		int           cnt;
		int           i;
		r.status     = ST_OK;
		r.read_value = '0;
		r.found_slot = '0;
		cnt          = int'(st.count);
		case (k)
			K_CLEAR: begin
				st.count = '0;
			end
			K_INSERT: begin
				if (cnt >= DEPTH) begin
					r.status = ST_FULL;
				end else if (int'(s) > cnt) begin
					r.status = ST_BAD_POS;
				end else begin
					for (i = cnt; i > int'(s); i--)
						st.entries[i] = st.entries[i-1];
					st.entries[s] = v;
					st.count      = 7'(cnt + 1);
				end
			end
			K_DELETE: begin
				if (int'(s) >= cnt) begin
					r.status = ST_BAD_POS;
				end else begin
					for (i = int'(s); i + 1 < cnt; i++)
						st.entries[i] = st.entries[i+1];
					st.count = 7'(cnt - 1);
				end
			end
			K_LOCATE: begin
				i = 0;
				while (i < cnt && st.entries[i] != v)
					i++;
				if (i < cnt) begin
					r.found_slot = 7'(i);
				end else begin
					r.status     = ST_NOT_FOUND;
					r.found_slot = 7'(cnt);
				end
			end
			K_READ: begin
				if (int'(s) >= cnt)
					r.status = ST_BAD_POS;
				else
					r.read_value = st.entries[s];
			end
			default: begin
				r.status = ST_BAD_POS;
			end
		endcase
		if (k != K_LOCATE)
			r.found_slot = st.count;
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(3))
			0, 1: return $urandom;
			2: return 32'($urandom_range(7));
			default: begin
				case ($urandom_range(3))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					default: return 32'h0000_0001;
				endcase
			end
		endcase
	endfunction

	// Mostly a slot inside the list when it has entries, else anywhere
	function automatic logic [5:0] pick_live_slot(int cnt);
		if (cnt > 0 && $urandom_range(99) < 85)
			return 6'($urandom_range(cnt - 1));
		return 6'($urandom_range(63));
	endfunction

	function automatic logic [31:0] pick_search_value(list_state_t st);
		if (st.count != 0 && $urandom_range(99) < 60)
			return st.entries[$urandom_range(int'(st.count) - 1)];
		return pick_value();
	endfunction

	function automatic int phase_of(int sent, int total);
		return (sent * 3) / total;
	endfunction

	function automatic int send_idle_pct(int sent, int total);
		case (phase_of(sent, total))
			0: return 29;
			1: return 78;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct(int sent, int total);
		case (phase_of(sent, total))
			0: return 78;
			1: return 29;
			default: return 0;
		endcase
	endfunction

	task automatic add_request(input logic [2:0] k, input logic [5:0] s, input logic [31:0] v);
		list_result_t unused_res;
		list_request_t w;
		unused_res = list_apply(gen_list, k, s, v);
		w.kind     = k;
		w.slot     = s;
		w.value    = v;
		pending_words.push_back(w);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h, want %0h", what, got, want);
		error_count++;
	endtask

	// Drive request words; hold a stalled word, advance after acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			kind       <= '0;
			slot       <= '0;
			value      <= '0;
			sent_words <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted = list_apply(model_list, kind, slot, value);
				result_queue.push_back(predicted);
				sent_words <= sent_words + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 &&
						$urandom_range(99) >= send_idle_pct(sent_words, total_words)) begin
					next_word = pending_words.pop_front();
					in_valid <= 1'b1;
					kind     <= next_word.kind;
					slot     <= next_word.slot;
					value    <= next_word.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check each accepted result word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_queue.size() == 0) begin
					report_mismatch("unexpected result word, status", 32'(status), '0);
				end else begin
					oldest = result_queue.pop_front();
					if (status !== oldest.status)
						report_mismatch("status", 32'(status), 32'(oldest.status));
					if (read_value !== oldest.read_value)
						report_mismatch("read_value", read_value, oldest.read_value);
					if (found_slot !== oldest.found_slot)
						report_mismatch("found_slot", 32'(found_slot), 32'(oldest.found_slot));
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct(sent_words, total_words));
		end
	end

	initial begin
		int episode;
		int n;
		int j;
		int k;
		gen_list   = '0;
		model_list = '0;

		// Directed: empty list, unused kinds, bounds, duplicates, clear
		add_request(K_READ,   6'd0,  32'h0);
		add_request(K_DELETE, 6'd0,  32'h0);
		add_request(K_LOCATE, 6'd0,  32'h0);
		for (k = K_READ + 1; k < 8; k++)
			add_request(3'(k), 6'd63, 32'hFFFF_FFFF);
		add_request(K_INSERT, 6'd1,  32'h1111_1111);
		add_request(K_INSERT, 6'd0,  32'hFFFF_FFFF);
		add_request(K_INSERT, 6'd0,  32'h0000_0000);
		add_request(K_INSERT, 6'd2,  32'hA5A5_A5A5);
		add_request(K_INSERT, 6'd1,  32'hFFFF_FFFF);
		add_request(K_LOCATE, 6'd0,  32'hFFFF_FFFF);
		add_request(K_LOCATE, 6'd63, 32'h5A5A_5A5A);
		add_request(K_READ,   6'd3,  32'h0);
		add_request(K_READ,   6'd4,  32'h0);
		add_request(K_READ,   6'd63, 32'h0);
		add_request(K_INSERT, 6'd63, 32'h7777_7777);
		add_request(K_DELETE, 6'd4,  32'h0);
		add_request(K_DELETE, 6'd1,  32'h0);
		add_request(K_DELETE, 6'd2,  32'h0);
		add_request(K_CLEAR,  6'd0,  32'h0);
		add_request(K_READ,   6'd0,  32'h0);
		add_request(K_LOCATE, 6'd0,  32'h0);
		add_request(K_INSERT, 6'd0,  32'h1234_5678);
		add_request(K_READ,   6'd0,  32'h0);
		add_request(K_DELETE, 6'd0,  32'h0);

		n       = pending_words.size() + N_RANDOM;
		episode = 0;
		while (pending_words.size() < n) begin
			episode++;
			if (episode == 1 || $urandom_range(7) == 0) begin
				// Fill to the top, then poke at the full list
				while (gen_list.count < DEPTH)
					add_request(K_INSERT, 6'($urandom_range(int'(gen_list.count))), pick_value());
				add_request(K_INSERT, 6'($urandom_range(63)), pick_value());
				add_request(K_INSERT, 6'd63, 32'hFFFF_FFFF);
				add_request(K_READ,   6'd63, 32'h0);
				add_request(K_LOCATE, 6'd0,  pick_search_value(gen_list));
				add_request(K_LOCATE, 6'd63, pick_value());
				add_request(K_DELETE, 6'($urandom_range(63)), 32'h0);
				add_request(K_INSERT, 6'd63, pick_value());
			end else begin
				for (j = $urandom_range(30, 12); j > 0; j--) begin
					k = $urandom_range(99);
					if (k < 35) begin
						if ($urandom_range(99) < 85)
							add_request(K_INSERT,
								6'($urandom_range(int'(gen_list.count) > 63 ? 63 :
									int'(gen_list.count))), pick_value());
						else
							add_request(K_INSERT, 6'($urandom_range(63)), pick_value());
					end else if (k < 50) begin
						add_request(K_DELETE, pick_live_slot(int'(gen_list.count)), $urandom);
					end else if (k < 70) begin
						add_request(K_LOCATE, 6'($urandom_range(63)),
							pick_search_value(gen_list));
					end else if (k < 90) begin
						add_request(K_READ, pick_live_slot(int'(gen_list.count)), $urandom);
					end else if (k < 95) begin
						add_request(K_CLEAR, 6'($urandom_range(63)), $urandom);
					end else begin
						add_request(3'($urandom_range(7, K_READ + 1)), 6'($urandom_range(63)),
							$urandom);
					end
				end
			end
		end
		total_words = pending_words.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || in_valid || result_queue.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/alte_pkg.sv
sv/alte_cell.sv
sv/array_list_table_engine.sv
test/tb_top.sv
